### hw/rtl/multi_plane_voxel_store_assert.svh
// Assertion macros for the voxel store.
`ifndef MULTI_PLANE_VOXEL_STORE_ASSERT_SVH
`define MULTI_PLANE_VOXEL_STORE_ASSERT_SVH

`ifndef SYNTHESIS

`define MPVS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpvs assertion failed");

`define MPVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpvs assertion failed");

`else

`define MPVS_ASSERT_SAME(lbl, ante, cons)

`define MPVS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/mpvs_pkg.sv
package mpvs_pkg;

	localparam int MAX_PLANES = 4;
	localparam int MAX_VOXELS = 4096;
	localparam int IDX_W      = $clog2(MAX_VOXELS);
	localparam int PL_W       = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int NP_W       = $clog2(MAX_PLANES + 1);
	localparam int SIZE_W     = 13;
	localparam int SXY_W      = 2 * SIZE_W;
	localparam int CMD_DEPTH  = 4;
	localparam int CMD_PW     = $clog2(CMD_DEPTH);

	localparam logic [1:0] KIND_READ_ONE  = 2'd0;
	localparam logic [1:0] KIND_WRITE_ONE = 2'd1;
	localparam logic [1:0] KIND_READ_ALL  = 2'd2;
	localparam logic [1:0] KIND_NONE      = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
	localparam logic [1:0] STAT_NO_PLANE = 2'd2;

	localparam logic [1:0] WCODE_8  = 2'd0;
	localparam logic [1:0] WCODE_16 = 2'd1;

	localparam logic [2:0] REG_LOW_X       = 3'd0;
	localparam logic [2:0] REG_LOW_Y       = 3'd1;
	localparam logic [2:0] REG_LOW_Z       = 3'd2;
	localparam logic [2:0] REG_SIZE_X      = 3'd3;
	localparam logic [2:0] REG_SIZE_Y      = 3'd4;
	localparam logic [2:0] REG_SIZE_Z      = 3'd5;
	localparam logic [2:0] REG_PLANE_COUNT = 3'd6;
	localparam logic [2:0] REG_WIDTH_CODES = 3'd7;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         plane_sel;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        wr_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] rd_value;
		logic [7:0]  plane_index;
		logic [1:0]  status;
		logic        materialised;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] low_x;
		logic signed [31:0] low_y;
		logic signed [31:0] low_z;
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
		logic [SXY_W-1:0]   sxy;
		logic [2:0]         plane_count;
		logic [7:0]         width_codes;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       sel;
		logic [31:0]      wval;
		logic             in_box;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	function automatic logic [31:0] value_mask(logic [7:0] codes, logic [7:0] plane);
		logic [1:0] code;
		unique case (plane)
			8'd0:    code = codes[1:0];
			8'd1:    code = codes[3:2];
			8'd2:    code = codes[5:4];
			8'd3:    code = codes[7:6];
			default: code = 2'd2;
		endcase
		if (code == WCODE_8) begin
			return 32'h0000_00ff;
		end else if (code == WCODE_16) begin
			return 32'h0000_ffff;
		end
		return 32'hffff_ffff;
	endfunction

endpackage

### hw/rtl/mpvs_front.sv
module mpvs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  mpvs_pkg::cfg_t     cfg,
	input  logic               push,
	output logic               full,
	input  mpvs_pkg::in_item_t req,
	input  logic               back_ready,
	input  logic               q_full,
	output logic               q_push,
	output mpvs_pkg::cmd_t     q_data
);

	logic        adv;
	logic        acc;
	logic        v_s1, v_s2;
	logic [1:0]  kind_s1, kind_s2;
	logic [7:0]  sel_s1, sel_s2;
	logic [31:0] wval_s1, wval_s2;
	logic [32:0] dx_s1, dy_s1, dz_s1;
	logic        ok_s2;
	logic [mpvs_pkg::SIZE_W-1:0] dx_s2;
	logic [mpvs_pkg::SXY_W-1:0]  py_s2;
	logic [mpvs_pkg::SXY_W+mpvs_pkg::SIZE_W-1:0] pz_s2;
	logic        ok_x, ok_y, ok_z;
	logic [mpvs_pkg::SXY_W+mpvs_pkg::SIZE_W:0] sum;

	assign adv  = !(v_s2 && q_full);
	assign full = !adv || !back_ready;
	assign acc  = push && !full;

	// signed distance from the lower corner, then the range check
	assign ok_x = !dx_s1[32] && (dx_s1[31:0] < 32'(cfg.size_x));
	assign ok_y = !dy_s1[32] && (dy_s1[31:0] < 32'(cfg.size_y));
	assign ok_z = !dz_s1[32] && (dz_s1[31:0] < 32'(cfg.size_z));

	assign sum = ($bits(sum))'(dx_s2) + ($bits(sum))'(py_s2) + ($bits(sum))'(pz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= req.kind;
			sel_s1  <= req.plane_sel;
			wval_s1 <= req.wr_value;
			dx_s1   <= {req.pos_x[31], req.pos_x} - {cfg.low_x[31], cfg.low_x};
			dy_s1   <= {req.pos_y[31], req.pos_y} - {cfg.low_y[31], cfg.low_y};
			dz_s1   <= {req.pos_z[31], req.pos_z} - {cfg.low_z[31], cfg.low_z};
			kind_s2 <= kind_s1;
			sel_s2  <= sel_s1;
			wval_s2 <= wval_s1;
			ok_s2   <= ok_x && ok_y && ok_z;
			dx_s2   <= dx_s1[mpvs_pkg::SIZE_W-1:0];
			py_s2   <= mpvs_pkg::SXY_W'(dy_s1[mpvs_pkg::SIZE_W-1:0])
				* mpvs_pkg::SXY_W'(cfg.size_x);
			pz_s2   <= ($bits(pz_s2))'(dz_s1[mpvs_pkg::SIZE_W-1:0])
				* ($bits(pz_s2))'(cfg.sxy);
		end
	end

	assign q_push        = v_s2 && adv && (kind_s2 != mpvs_pkg::KIND_NONE);
	assign q_data.kind   = kind_s2;
	assign q_data.sel    = sel_s2;
	assign q_data.wval   = wval_s2;
	assign q_data.in_box = ok_s2 && (sum < ($bits(sum))'(mpvs_pkg::MAX_VOXELS));
	assign q_data.idx    = sum[mpvs_pkg::IDX_W-1:0];

endmodule

### hw/rtl/mpvs_cmd_fifo.sv
module mpvs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mpvs_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output mpvs_pkg::cmd_t rdata,
	output logic           empty
);

	mpvs_pkg::cmd_t             mem_q [mpvs_pkg::CMD_DEPTH];
	logic [mpvs_pkg::CMD_PW-1:0] wr_q, rd_q;
	logic [mpvs_pkg::CMD_PW:0]   cnt_q;
	logic                        do_push, do_pop;

	assign full    = (cnt_q == (mpvs_pkg::CMD_PW+1)'(mpvs_pkg::CMD_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

### hw/rtl/mpvs_back.sv
module mpvs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mpvs_pkg::cfg_t      cfg,
	output logic                ready,
	input  logic                cmd_empty,
	input  mpvs_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output mpvs_pkg::out_item_t rsp
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [mpvs_pkg::IDX_W-1:0]      clr_q;
	logic [mpvs_pkg::PL_W-1:0]       p_q;
	logic [mpvs_pkg::MAX_PLANES-1:0] written_q;
	mpvs_pkg::cmd_t                  cur_q;
	mpvs_pkg::out_item_t             out_q [2];
	logic                            out_wr_q, out_rd_q;
	logic [1:0]                      out_cnt_q;

	logic [31:0] rdata_q [mpvs_pkg::MAX_PLANES];
	logic [31:0] wdata [mpvs_pkg::MAX_PLANES];
	logic [mpvs_pkg::MAX_PLANES-1:0] we;
	logic [mpvs_pkg::IDX_W-1:0]      addr;
	logic                            re;
	logic                            clearing;
	logic                            take;
	logic [mpvs_pkg::NP_W-1:0]       np;
	logic [mpvs_pkg::PL_W-1:0]       wr_sp;
	logic                            wr_do;
	logic                            emit_go;
	logic                            out_pop;
	mpvs_pkg::out_item_t             res;
	logic [mpvs_pkg::PL_W-1:0]       sp;
	logic                            sel_ok;

	assign clearing = (state_q == ST_CLEAR);
	assign ready    = !clearing;
	assign take     = (state_q == ST_IDLE) && !cmd_empty;
	assign cmd_pop  = take;
	assign np       = (cfg.plane_count < 3'(mpvs_pkg::MAX_PLANES))
		? mpvs_pkg::NP_W'(cfg.plane_count) : mpvs_pkg::NP_W'(mpvs_pkg::MAX_PLANES);

	assign wr_sp = cmd.sel[mpvs_pkg::PL_W-1:0];
	assign wr_do = take && (cmd.kind == mpvs_pkg::KIND_WRITE_ONE) && cmd.in_box
		&& (cmd.sel < 8'(np)) && ((cmd.wval != '0) || written_q[wr_sp]);
	assign re    = take && cmd.in_box && (cmd.kind != mpvs_pkg::KIND_WRITE_ONE);
	assign addr  = clearing ? clr_q : cmd.idx;

	always_comb begin
		for (int p = 0; p < mpvs_pkg::MAX_PLANES; p++) begin
			we[p]    = clearing || (wr_do && (wr_sp == mpvs_pkg::PL_W'(p)));
			wdata[p] = clearing ? 32'd0
				: (cmd.wval & mpvs_pkg::value_mask(cfg.width_codes, 8'(p)));
		end
	end

	for (genvar gp = 0; gp < mpvs_pkg::MAX_PLANES; gp++) begin : g_plane
		logic [31:0] mem [mpvs_pkg::MAX_VOXELS];

		always_ff @(posedge clk) begin
			if (we[gp]) begin
				mem[addr] <= wdata[gp];
			end
			if (re) begin
				rdata_q[gp] <= mem[addr];
			end
		end
	end

	// one result per cycle in EMIT while the output buffer has room
	assign sp     = cur_q.sel[mpvs_pkg::PL_W-1:0];
	assign sel_ok = cur_q.sel < 8'(np);

	always_comb begin
		res = '0;
		priority if (cur_q.kind != mpvs_pkg::KIND_READ_ALL) begin
			res.plane_index = cur_q.sel;
			res.last        = 1'b1;
			if (!cur_q.in_box) begin
				res.status = mpvs_pkg::STAT_OUTSIDE;
			end else if (!sel_ok) begin
				res.status = mpvs_pkg::STAT_NO_PLANE;
			end else begin
				res.status = mpvs_pkg::STAT_OK;
			end
			res.materialised = sel_ok && written_q[sp];
			if (cur_q.kind == mpvs_pkg::KIND_READ_ONE && res.status == mpvs_pkg::STAT_OK) begin
				res.rd_value = rdata_q[sp] & mpvs_pkg::value_mask(cfg.width_codes, cur_q.sel);
			end
		end else if (np == '0) begin
			res.status = cur_q.in_box ? mpvs_pkg::STAT_NO_PLANE : mpvs_pkg::STAT_OUTSIDE;
			res.last   = 1'b1;
		end else begin
			res.plane_index  = 8'(p_q);
			res.status       = cur_q.in_box ? mpvs_pkg::STAT_OK : mpvs_pkg::STAT_OUTSIDE;
			res.materialised = written_q[p_q];
			res.last         = (mpvs_pkg::NP_W'(p_q) + 1'b1) == np;
			if (cur_q.in_box) begin
				res.rd_value = rdata_q[p_q] & mpvs_pkg::value_mask(cfg.width_codes, 8'(p_q));
			end
		end
	end

	assign emit_go = (state_q == ST_EMIT) && (out_cnt_q != 2'd2);
	assign empty   = (out_cnt_q == 2'd0);
	assign out_pop = pop && !empty;
	assign rsp     = out_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			p_q       <= '0;
			written_q <= '0;
			cur_q     <= '0;
			out_q[0]  <= '0;
			out_q[1]  <= '0;
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == mpvs_pkg::IDX_W'(mpvs_pkg::MAX_VOXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						cur_q <= cmd;
						p_q   <= '0;
						if (wr_do && (cmd.wval != '0)) begin
							written_q[wr_sp] <= 1'b1;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (res.last) begin
							state_q <= ST_IDLE;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit_go) begin
				out_q[out_wr_q] <= res;
				out_wr_q        <= !out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= !out_rd_q;
			end
			if (emit_go && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_pop && !emit_go) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/multi_plane_voxel_store.sv
// An item passes two front stages, the command queue, then back-end IDLE and EMIT
// before its first result can be popped. The back end ends each item (one result for
// single plane kinds, one per plane in use, at least 1, for read-all) before taking the
// next; one port per plane memory. The front end accepts one item per cycle outside
// the clear pass until its two stages and 4-entry queue fill. Reset: state and config
// registers take defaults, then all plane memories are cleared with full held high.
`include "multi_plane_voxel_store_assert.svh"

module multi_plane_voxel_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mpvs_pkg::in_item_t  req,
	output logic                empty,
	input  logic                pop,
	output mpvs_pkg::out_item_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	mpvs_pkg::cfg_t cfg_q;
	logic           back_ready;
	logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
	mpvs_pkg::cmd_t cmd_in, cmd_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_x       <= '0;
			cfg_q.low_y       <= '0;
			cfg_q.low_z       <= '0;
			cfg_q.size_x      <= mpvs_pkg::SIZE_W'(16);
			cfg_q.size_y      <= mpvs_pkg::SIZE_W'(16);
			cfg_q.size_z      <= mpvs_pkg::SIZE_W'(16);
			cfg_q.sxy         <= mpvs_pkg::SXY_W'(256);
			cfg_q.plane_count <= 3'd1;
			cfg_q.width_codes <= 8'd170;
		end else begin
			cfg_q.sxy <= mpvs_pkg::SXY_W'(cfg_q.size_x) * mpvs_pkg::SXY_W'(cfg_q.size_y);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mpvs_pkg::REG_LOW_X:       cfg_q.low_x <= cfg_data;
					mpvs_pkg::REG_LOW_Y:       cfg_q.low_y <= cfg_data;
					mpvs_pkg::REG_LOW_Z:       cfg_q.low_z <= cfg_data;
					mpvs_pkg::REG_SIZE_X:      cfg_q.size_x <= cfg_data[mpvs_pkg::SIZE_W-1:0];
					mpvs_pkg::REG_SIZE_Y:      cfg_q.size_y <= cfg_data[mpvs_pkg::SIZE_W-1:0];
					mpvs_pkg::REG_SIZE_Z:      cfg_q.size_z <= cfg_data[mpvs_pkg::SIZE_W-1:0];
					mpvs_pkg::REG_PLANE_COUNT: cfg_q.plane_count <= cfg_data[2:0];
					mpvs_pkg::REG_WIDTH_CODES: cfg_q.width_codes <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	mpvs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.req        (req),
		.back_ready (back_ready),
		.q_full     (cmd_full),
		.q_push     (cmd_push),
		.q_data     (cmd_in)
	);

	mpvs_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	mpvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ready     (back_ready),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	`MPVS_ASSERT_SAME(a_full_while_clearing, !back_ready, full)
	`MPVS_ASSERT_SAME(a_no_cmd_overflow, cmd_push, !cmd_full)
	`MPVS_ASSERT_SAME(a_outside_reads_zero, !empty && rsp.status == mpvs_pkg::STAT_OUTSIDE, rsp.rd_value == 32'd0)
	`MPVS_ASSERT_SAME(a_missing_plane_clean, !empty && rsp.status == mpvs_pkg::STAT_NO_PLANE, !rsp.materialised && rsp.rd_value == 32'd0)

endmodule

### tb/sv/voxel_mirror_pkg.sv
package voxel_mirror_pkg;

	import mpvs_pkg::*;

	class voxel_store_mirror;

		int          low_x;
		int          low_y;
		int          low_z;
		longint      size_x;
		longint      size_y;
		longint      size_z;
		bit [2:0]    plane_count;
		bit [7:0]    width_codes;
		bit [31:0]   cells [MAX_PLANES*MAX_VOXELS];
		bit          written [MAX_PLANES];
		out_item_t   awaited [$];
		int          failures;

		function new();
			low_x = 0;
			low_y = 0;
			low_z = 0;
			size_x = 16;
			size_y = 16;
			size_z = 16;
			plane_count = 3'd1;
			width_codes = 8'd170;
			failures = 0;
		endfunction

		function void write_reg(logic [2:0] index, logic [31:0] data);
			case (index)
				REG_LOW_X:       low_x = data;
				REG_LOW_Y:       low_y = data;
				REG_LOW_Z:       low_z = data;
				REG_SIZE_X:      size_x = data[12:0];
				REG_SIZE_Y:      size_y = data[12:0];
				REG_SIZE_Z:      size_z = data[12:0];
				REG_PLANE_COUNT: plane_count = data[2:0];
				REG_WIDTH_CODES: width_codes = data[7:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] plane_bits(int p);
			bit [1:0] code;
			code = 2'd2;
			if (p < 4)
				code = width_codes[2*p +: 2];
			if (code == WCODE_8)
				return 32'h0000_00ff;
			if (code == WCODE_16)
				return 32'h0000_ffff;
			return 32'hffff_ffff;
		endfunction

		// box test plus capacity test; idx valid only when 1 is returned
		function bit find_cell(in_item_t it, output int idx);
			longint dx;
			longint dy;
			longint dz;
			longint lin;
			idx = 0;
			dx = longint'(it.pos_x) - longint'(low_x);
			dy = longint'(it.pos_y) - longint'(low_y);
			dz = longint'(it.pos_z) - longint'(low_z);
			if (dx < 0 || dy < 0 || dz < 0)
				return 1'b0;
			if (dx >= size_x || dy >= size_y || dz >= size_z)
				return 1'b0;
			lin = dx + dy * size_x + dz * size_x * size_y;
			if (lin >= MAX_VOXELS)
				return 1'b0;
			idx = int'(lin);
			return 1'b1;
		endfunction

		function void add_expected(bit [31:0] value, int plane, logic [1:0] status,
				bit mat, bit last);
			out_item_t r;
			r.rd_value = value;
			r.plane_index = plane[7:0];
			r.status = status;
			r.materialised = mat;
			r.last = last;
			awaited = {awaited, r};
		endfunction

		function void note_item(in_item_t it);
			bit in_box;
			int idx;
			int np;
			int sel;
			bit [31:0] v;
			in_box = find_cell(it, idx);
			np = (plane_count < MAX_PLANES) ? plane_count : MAX_PLANES;
			sel = it.plane_sel;
			case (it.kind)
				KIND_READ_ONE, KIND_WRITE_ONE: begin
					if (!in_box) begin
						add_expected(0, sel, STAT_OUTSIDE, (sel < np) ? written[sel] : 1'b0, 1'b1);
					end else if (sel >= np) begin
						add_expected(0, sel, STAT_NO_PLANE, 1'b0, 1'b1);
					end else if (it.kind == KIND_READ_ONE) begin
						v = cells[sel*MAX_VOXELS + idx] & plane_bits(sel);
						add_expected(v, sel, STAT_OK, written[sel], 1'b1);
					end else begin
						if (it.wr_value != 0 || written[sel]) begin
							if (it.wr_value != 0)
								written[sel] = 1'b1;
							cells[sel*MAX_VOXELS + idx] = it.wr_value & plane_bits(sel);
						end
						add_expected(0, sel, STAT_OK, written[sel], 1'b1);
					end
				end
				KIND_READ_ALL: begin
					if (np == 0) begin
						add_expected(0, 0, in_box ? STAT_NO_PLANE : STAT_OUTSIDE, 1'b0, 1'b1);
					end else begin
						for (int p = 0; p < np; p++) begin
							v = in_box ? (cells[p*MAX_VOXELS + idx] & plane_bits(p)) : 32'd0;
							add_expected(v, p, in_box ? STAT_OK : STAT_OUTSIDE, written[p],
								p == np - 1);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, got);
				failures++;
				return;
			end
			want = awaited.pop_front();
			compare_field("rd_value", want.rd_value, got.rd_value);
			compare_field("plane_index", want.plane_index, got.plane_index);
			compare_field("status", want.status, got.status);
			compare_field("materialised", want.materialised, got.materialised);
			compare_field("last", want.last, got.last);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

	endclass

endpackage

### tb/sv/testbench.sv
module testbench;

	import mpvs_pkg::*;
	import voxel_mirror_pkg::*;

	localparam int INT_LO = 32'sh8000_0000;
	localparam int INT_HI = 32'sh7fff_ffff;
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEMS_PER_SETTING = 27;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    req = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_LOW_X;
	logic [31:0] cfg_data = '0;

	int tx_idle_pct = 32;
	int rx_idle_pct = 61;
	int hold_request = 0;
	int quiet_cycles = 0;

	voxel_store_mirror sb;

	multi_plane_voxel_store uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// outputs only change at the rising edge, so values seen here hold at the next one
	always @(negedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (push && !full)
				sb.note_item(req);
			if (pop && !empty)
				sb.check_result(rsp);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("[multi_plane_voxel_store] ERROR");
				$finish;
			end
		end
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_op(input logic [1:0] kind, input int sel, input int x, input int y,
			input int z, input logic [31:0] val);
		in_item_t it;
		it.kind = kind;
		it.plane_sel = sel[7:0];
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		it.wr_value = val;
		if ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		push <= 1'b1;
		req <= it;
		do @(negedge clk); while (full);
		@(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
	endtask

	task automatic send_reg(input logic [2:0] index, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic configure(input int lx, input int ly, input int lz, input int sx,
			input int sy, input int sz, input int pc, input int codes);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		send_reg(REG_LOW_X, lx);
		send_reg(REG_LOW_Y, ly);
		send_reg(REG_LOW_Z, lz);
		send_reg(REG_SIZE_X, sx);
		send_reg(REG_SIZE_Y, sy);
		send_reg(REG_SIZE_Z, sz);
		send_reg(REG_PLANE_COUNT, pc);
		send_reg(REG_WIDTH_CODES, codes);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_coord(int low, longint size);
		int r;
		r = $urandom_range(9);
		if (r < 8 && size > 0)
			return low + int'($urandom_range(int'(size) - 1));
		if (r < 9)
			return $urandom_range(1) ? low - 1 : low + int'(size);
		return $urandom;
	endfunction

	task automatic random_config();
		int lows[3];
		int dims[3];
		int r;
		int pc;
		for (int i = 0; i < 3; i++) begin
			r = $urandom_range(3);
			if (r < 2)
				lows[i] = int'($urandom_range(16)) - 8;
			else if (r == 2)
				lows[i] = $urandom;
			else
				lows[i] = $urandom_range(1) ? INT_HI - 2 : INT_LO;
		end
		dims[0] = $urandom_range(8, 1);
		dims[1] = $urandom_range(6, 1);
		dims[2] = $urandom_range(4, 1);
		if ($urandom_range(7) == 0)
			dims[$urandom_range(2)] = 4096;
		pc = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
		configure(lows[0], lows[1], lows[2], dims[0], dims[1], dims[2], pc,
			$urandom_range(255));
	endtask

	task automatic random_op(output bit counted);
		int r;
		int np;
		int sel;
		logic [1:0] kind;
		logic [31:0] val;
		r = $urandom_range(99);
		if (r < 40)
			kind = KIND_WRITE_ONE;
		else if (r < 72)
			kind = KIND_READ_ONE;
		else if (r < 94)
			kind = KIND_READ_ALL;
		else
			kind = KIND_NONE;
		np = (sb.plane_count > MAX_PLANES) ? MAX_PLANES : sb.plane_count;
		if ($urandom_range(99) < 85 && np > 0)
			sel = $urandom_range(np - 1);
		else
			sel = $urandom_range(255);
		r = $urandom_range(9);
		if (r < 2)
			val = '0;
		else if (r < 5)
			val = $urandom_range(255);
		else
			val = $urandom;
		send_op(kind, sel, pick_coord(sb.low_x, sb.size_x), pick_coord(sb.low_y, sb.size_y),
			pick_coord(sb.low_z, sb.size_z), val);
		counted = (kind != KIND_NONE);
	endtask

	initial begin : stimulus
		bit counted;
		int done;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: 16x16x16 box at the origin, one 32-bit plane
		send_op(KIND_READ_ONE, 0, 0, 0, 0, 32'h0);
		send_op(KIND_WRITE_ONE, 0, 0, 0, 0, 32'h0);
		send_op(KIND_READ_ALL, 0, 0, 0, 0, 32'h0);
		send_op(KIND_WRITE_ONE, 0, 15, 15, 15, 32'hffff_ffff);
		send_op(KIND_READ_ONE, 0, 15, 15, 15, 32'h0);
		send_op(KIND_READ_ONE, 0, 16, 15, 15, 32'h0);
		send_op(KIND_READ_ONE, 0, -1, 0, 0, 32'h0);
		send_op(KIND_WRITE_ONE, 0, 0, 0, 16, 32'h1234_5678);
		send_op(KIND_READ_ONE, 1, 1, 1, 1, 32'h0);
		send_op(KIND_WRITE_ONE, 255, 0, 0, 0, 32'h5);
		send_op(KIND_READ_ONE, 1, -1, 0, 0, 32'h0);
		send_op(KIND_NONE, 0, 0, 0, 0, 32'hffff_ffff);
		send_op(KIND_WRITE_ONE, 0, 15, 15, 15, 32'h0);
		send_op(KIND_READ_ONE, 0, 15, 15, 15, 32'h0);

		// corner at the signed extremes, x beyond capacity, 8/16/32/code-3 planes
		configure(INT_LO, INT_HI, -3, 4096, 1, 2, 7, 8'hE4);
		send_op(KIND_WRITE_ONE, 0, INT_LO, INT_HI, -3, 32'hdead_beef);
		send_op(KIND_WRITE_ONE, 1, INT_LO, INT_HI, -3, 32'hdead_beef);
		send_op(KIND_WRITE_ONE, 2, INT_LO, INT_HI, -3, 32'hdead_beef);
		send_op(KIND_WRITE_ONE, 3, INT_LO + 4095, INT_HI, -3, 32'hdead_beef);
		send_op(KIND_READ_ALL, 0, INT_LO, INT_HI, -3, 32'h0);
		send_op(KIND_READ_ONE, 3, INT_LO + 4095, INT_HI, -3, 32'h0);
		send_op(KIND_READ_ALL, 0, INT_LO, INT_HI, -2, 32'h0);
		send_op(KIND_READ_ONE, 4, INT_LO, INT_HI, -3, 32'h0);
		send_op(KIND_READ_ALL, 0, INT_LO, INT_LO, -3, 32'h0);

		// no planes in use
		configure(0, 0, 0, 2, 2, 2, 0, 8'h00);
		send_op(KIND_READ_ALL, 0, 1, 1, 1, 32'h0);
		send_op(KIND_READ_ALL, 0, 5, 0, 0, 32'h0);
		send_op(KIND_READ_ONE, 0, 0, 0, 0, 32'h0);

		// empty box
		configure(0, 0, 0, 0, 1, 1, 2, 8'h55);
		send_op(KIND_WRITE_ONE, 0, 0, 0, 0, 32'hffff_ffff);
		send_op(KIND_READ_ALL, 1, 0, 0, 0, 32'h0);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				tx_idle_pct = 61;
				rx_idle_pct = 32;
			end else if (phase == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int setting = 0; setting < 3; setting++) begin
				random_config();
				if (phase == 2 && setting == 0)
					hold_request = 300;
				done = 0;
				while (done < ITEMS_PER_SETTING) begin
					random_op(counted);
					if (counted)
						done++;
				end
				if (phase == 2 && setting == 0)
					drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("[multi_plane_voxel_store] OK");
		else
			$display("[multi_plane_voxel_store] ERROR");
		$finish;
	end

endmodule
